// ----- hdl/ups_status_packet_receiver_macros.svh -----
// assertion macros for the ups status packet receiver
`ifndef UPS_STATUS_PACKET_RECEIVER_MACROS_SVH
`define UPS_STATUS_PACKET_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle as the trigger
`define USP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define USP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define USP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define USP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/usp_pkg.sv -----
package usp_pkg;

	// serial byte with end-of-read marker
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} rx_item_t;

	// decoded status fields, held between good packets
	typedef struct packed {
		logic [1:0] model_code;
		logic       output_on;
		logic       input_on;
		logic       bypass_on;
		logic       low_battery;
		logic       overcharge;
		logic       source_fail;
		logic       battery_critical;
		logic [1:0] line_event;
		logic [2:0] output_event;
		logic [8:0] output_voltage_half;
	} status_t;

	// one report per chunk
	typedef struct packed {
		logic    packet_ok;
		status_t st;
	} report_t;

	// line event codes
	localparam logic [1:0] LINE_NONE   = 2'd0;
	localparam logic [1:0] LINE_FAIL   = 2'd1;
	localparam logic [1:0] LINE_RETURN = 2'd2;

	// output event codes
	localparam logic [2:0] OUT_NONE      = 3'd0;
	localparam logic [2:0] OUT_INV_ON    = 3'd1;
	localparam logic [2:0] OUT_INV_OFF   = 3'd2;
	localparam logic [2:0] OUT_OVC_START = 3'd3;
	localparam logic [2:0] OUT_OVC_END   = 3'd4;

	// register map
	localparam logic REG_LIMIT_6KVA  = 1'b0;
	localparam logic REG_LIMIT_OTHER = 1'b1;
	localparam logic [7:0] LIMIT_6KVA_RST  = 8'd174;
	localparam logic [7:0] LIMIT_OTHER_RST = 8'd126;

	// packet layout
	localparam logic [5:0] POS_HDR   = 6'd0;
	localparam logic [5:0] POS_VIN   = 6'd2;
	localparam logic [5:0] POS_VOUT  = 6'd11;
	localparam logic [5:0] POS_VBAT  = 6'd20;
	localparam logic [5:0] POS_FLAG1 = 6'd33;
	localparam logic [5:0] POS_FLAG2 = 6'd34;
	localparam logic [5:0] POS_FLAG3 = 6'd35;
	localparam logic [5:0] POS_SUM   = 6'd36;
	localparam logic [5:0] COUNT_SAT = 6'd38;

	localparam logic [7:0] HDR_MIN  = 8'hC0;
	localparam logic [7:0] HDR_MAX  = 8'hC3;
	localparam logic [7:0] HDR_6KVA = 8'hC2;
	localparam logic [8:0] BYPASS_OFFSET = 9'd10;

endpackage

// ----- hdl/ups_status_packet_receiver.sv -----
// ups status packet receiver
// rx channel: one serial byte per transaction (rx_valid / rx_stall / rx_data);
//   rx_data.chunk_end marks the last byte of one serial read
// rpt channel: one report per chunk (rpt_valid / rpt_stall / rpt_data), nothing
//   for the other bytes; a good chunk is exactly 37 bytes, header 0xc0..0xc3,
//   byte 36 equal to the low 8 bits of the sum of bytes 0..35
// a bad chunk repeats the last good status with packet_ok cleared
// apb port: register 0 (addr 0) battery limit for header 0xc2, register 1
//   (addr 4) limit for the other headers; pready is tied high
// the report appears in the cycle after the transaction carrying chunk_end;
//   throughput is one byte per cycle, but a chunk end waits while rx_stall
//   is high; it is set by the byte counter and checksum accumulator and the
//   decode that sits between the captured-byte registers and the report register
// the report register doubles as the output stage: while a report waits,
//   ordinary bytes keep flowing in; only a chunk end is held off with rx_stall
//   while the report register is full and rpt_stall is high
// reset clears the byte counter, checksum, model latch, edge tracking, the
//   sticky critical flag and the held status; limits return to 174 and 126
`include "ups_status_packet_receiver_macros.svh"

module ups_status_packet_receiver (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// byte stream
	input  logic              rx_valid,
	output logic              rx_stall,
	input  usp_pkg::rx_item_t rx_data,
	// reports
	output logic              rpt_valid,
	input  logic              rpt_stall,
	output usp_pkg::report_t  rpt_data
);

	// configuration registers
	logic [7:0] limit_6kva_q;
	logic [7:0] limit_other_q;

	// chunk framing
	logic [5:0] cnt_q;
	logic [7:0] sum_q;

	// captured bytes of the current chunk
	logic [7:0] hdr_q;
	logic [7:0] vin_q;
	logic [7:0] vout_q;
	logic [7:0] vbat_q;
	logic [7:0] flag1_q;
	logic [7:0] flag2_q;
	logic [7:0] flag3_q;

	// persistent decode state
	logic             model_det_q;
	logic [1:0]       model_q;
	logic             line_good_q;
	logic             fail_q;
	logic             return_q;
	logic             prev_inv_q;
	logic             prev_ovc_q;
	logic             crit_q;
	usp_pkg::status_t held_q;

	// report register
	logic             rpt_valid_q;
	usp_pkg::report_t rpt_q;

	logic cfg_wr;
	logic rx_acc;
	logic chunk_done;
	logic pkt_ok;

	// decode of the finishing chunk
	logic             out_on, in_on, byp, lowb, ovc, sfail, good_now;
	logic [7:0]       limit;
	logic [1:0]       model_n;
	logic             crit_n;
	logic             fail_n, return_n;
	logic [1:0]       line_ev;
	logic [2:0]       out_ev;
	logic [8:0]       volt;
	usp_pkg::status_t status_n;

	// ---------------------------------------------------------------
	// apb register file
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_6kva_q  <= usp_pkg::LIMIT_6KVA_RST;
			limit_other_q <= usp_pkg::LIMIT_OTHER_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				usp_pkg::REG_LIMIT_6KVA:  limit_6kva_q  <= pwdata[7:0];
				usp_pkg::REG_LIMIT_OTHER: limit_other_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			usp_pkg::REG_LIMIT_6KVA:  prdata[7:0] = limit_6kva_q;
			usp_pkg::REG_LIMIT_OTHER: prdata[7:0] = limit_other_q;
			default: prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// handshake: only a chunk end needs room in the report register
	// ---------------------------------------------------------------
	assign rx_stall   = rpt_valid_q & rpt_stall & rx_data.chunk_end;
	assign rx_acc     = rx_valid & ~rx_stall;
	assign chunk_done = rx_acc & rx_data.chunk_end;

	// byte 36 is still on the input when the chunk closes
	assign pkt_ok = (cnt_q == usp_pkg::POS_SUM) &&
		(hdr_q >= usp_pkg::HDR_MIN) && (hdr_q <= usp_pkg::HDR_MAX) &&
		(rx_data.rx_byte == sum_q);

	// ---------------------------------------------------------------
	// byte counter, checksum and byte capture
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (rx_acc) begin
			if (rx_data.chunk_end) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				// long chunks stop counting and summing
				if (cnt_q < usp_pkg::COUNT_SAT)
					cnt_q <= cnt_q + 6'd1;
				if (cnt_q < usp_pkg::POS_SUM)
					sum_q <= sum_q + rx_data.rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			case (cnt_q)
				usp_pkg::POS_HDR:   hdr_q   <= rx_data.rx_byte;
				usp_pkg::POS_VIN:   vin_q   <= rx_data.rx_byte;
				usp_pkg::POS_VOUT:  vout_q  <= rx_data.rx_byte;
				usp_pkg::POS_VBAT:  vbat_q  <= rx_data.rx_byte;
				usp_pkg::POS_FLAG1: flag1_q <= rx_data.rx_byte;
				usp_pkg::POS_FLAG2: flag2_q <= rx_data.rx_byte;
				usp_pkg::POS_FLAG3: flag3_q <= rx_data.rx_byte;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// status decode
	// ---------------------------------------------------------------
	always_comb begin
		out_on   = flag1_q[1];
		in_on    = flag1_q[2];
		byp      = flag1_q[3];
		lowb     = flag2_q[6];
		ovc      = flag3_q[0];
		sfail    = flag3_q[1];
		good_now = ~sfail;

		// model comes from the first good header only
		model_n = model_det_q ? model_q : hdr_q[1:0];

		// limit follows this packet's header, not the latched model
		limit  = (hdr_q == usp_pkg::HDR_6KVA) ? limit_6kva_q : limit_other_q;
		crit_n = crit_q | (vbat_q < limit);

		// bypass reports input volts plus ten, else output volts doubled
		volt = byp ? ({1'b0, vin_q} + usp_pkg::BYPASS_OFFSET) : {vout_q, 1'b0};

		// line flags stay set until the line state repeats
		fail_n   = fail_q | (sfail & line_good_q);
		return_n = return_q | (~sfail & ~line_good_q);
		if (good_now == line_good_q) begin
			fail_n   = 1'b0;
			return_n = 1'b0;
		end
		line_ev = usp_pkg::LINE_NONE;
		if (fail_n)
			line_ev = usp_pkg::LINE_FAIL;
		if (return_n)
			line_ev = usp_pkg::LINE_RETURN;

		// overcharge edges override inverter edges
		out_ev = usp_pkg::OUT_NONE;
		if (in_on && !prev_inv_q)
			out_ev = usp_pkg::OUT_INV_ON;
		if (prev_inv_q && !in_on)
			out_ev = usp_pkg::OUT_INV_OFF;
		if (ovc && !prev_ovc_q)
			out_ev = usp_pkg::OUT_OVC_START;
		if (prev_ovc_q && !ovc)
			out_ev = usp_pkg::OUT_OVC_END;

		status_n.model_code          = model_n;
		status_n.output_on           = out_on;
		status_n.input_on            = in_on;
		status_n.bypass_on           = byp;
		status_n.low_battery         = lowb;
		status_n.overcharge          = ovc;
		status_n.source_fail         = sfail;
		status_n.battery_critical    = crit_n;
		status_n.line_event          = line_ev;
		status_n.output_event        = out_ev;
		status_n.output_voltage_half = volt;
	end

	// state moves only on a good packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_det_q <= 1'b0;
			model_q     <= '0;
			line_good_q <= 1'b0;
			fail_q      <= 1'b0;
			return_q    <= 1'b0;
			prev_inv_q  <= 1'b0;
			prev_ovc_q  <= 1'b0;
			crit_q      <= 1'b0;
			held_q      <= '0;
		end else if (chunk_done && pkt_ok) begin
			model_det_q <= 1'b1;
			model_q     <= model_n;
			line_good_q <= good_now;
			fail_q      <= fail_n;
			return_q    <= return_n;
			prev_inv_q  <= in_on;
			prev_ovc_q  <= ovc;
			crit_q      <= crit_n;
			held_q      <= status_n;
		end
	end

	// ---------------------------------------------------------------
	// report register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (chunk_done) begin
			rpt_valid_q <= 1'b1;
		end else if (!rpt_stall) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_done) begin
			rpt_q.packet_ok <= pkt_ok;
			rpt_q.st        <= pkt_ok ? status_n : held_q;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt_data  = rpt_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`USP_ASSERT_NEXT(a_chunk_reports, clk, arst_n, chunk_done, rpt_valid_q, "chunk end gave no report")
	`USP_ASSERT_NOW(a_cnt_sat, clk, arst_n, 1'b1, cnt_q <= usp_pkg::COUNT_SAT, "byte count past saturation")
	`USP_ASSERT_NOW(a_ok_model, clk, arst_n, rpt_valid_q && rpt_q.packet_ok, model_det_q, "good report without model latch")
	`USP_ASSERT_NOW(a_line_code, clk, arst_n, rpt_valid_q, rpt_q.st.line_event != 2'd3, "line event code out of range")

endmodule

// ----- tb/testbench.sv -----
module testbench;

	// run limit in clock cycles, well above the slowest legal run
	localparam int unsigned LIMIT_CYCLES = 400_000;
	localparam int unsigned PKT_BYTES = 37;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              rx_valid;
	logic              rx_stall;
	usp_pkg::rx_item_t rx_data;
	logic              rpt_valid;
	logic              rpt_stall;
	usp_pkg::report_t  rpt_data;

	ups_status_packet_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_data  (rx_data),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt_data (rpt_data)
	);

	// reports the receiver should produce, oldest first
	usp_pkg::report_t pending_reports[$];
	int unsigned      field_errors;
	int unsigned      bytes_sent;

	// random idling on both channels, off for back-to-back stretches
	bit          gaps_on;
	// long report hold-off requested by a test, consumed by the stall process
	int unsigned hold_off_len;

	// byte image of the next chunk to send
	logic [7:0]  chunk_buf[$];

	// receiver state as the testbench sees it
	logic [5:0]       rcv_count;
	logic [7:0]       rcv_sum;
	logic [7:0]       cap_hdr, cap_vin, cap_vout, cap_vbat;
	logic [7:0]       cap_f1, cap_f2, cap_f3, cap_sum;
	logic             model_seen;
	logic [1:0]       model_held;
	logic             line_good, fail_pend, return_pend;
	logic             prev_inverter, prev_ovc, crit_seen;
	usp_pkg::status_t held_status;
	logic [7:0]       lim_6kva, lim_other;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// hard stop in case the design hangs
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// update the expected state for one accepted byte, yield a report on chunk end
	task automatic predict_report(input usp_pkg::rx_item_t item, output logic has_rpt,
			output usp_pkg::report_t rpt);
		logic [5:0]  pos;
		logic        ok;
		logic        sfail, inv, ovc;
		logic [7:0]  limit;
		logic [1:0]  line_ev;
		logic [2:0]  out_ev;
		pos = rcv_count;
		if (pos < usp_pkg::POS_SUM)
			rcv_sum = rcv_sum + item.rx_byte;
		case (pos)
			usp_pkg::POS_HDR:   cap_hdr = item.rx_byte;
			usp_pkg::POS_VIN:   cap_vin = item.rx_byte;
			usp_pkg::POS_VOUT:  cap_vout = item.rx_byte;
			usp_pkg::POS_VBAT:  cap_vbat = item.rx_byte;
			usp_pkg::POS_FLAG1: cap_f1 = item.rx_byte;
			usp_pkg::POS_FLAG2: cap_f2 = item.rx_byte;
			usp_pkg::POS_FLAG3: cap_f3 = item.rx_byte;
			usp_pkg::POS_SUM:   cap_sum = item.rx_byte;
			default: ;
		endcase
		if (rcv_count < usp_pkg::COUNT_SAT)
			rcv_count = rcv_count + 6'd1;
		has_rpt = item.chunk_end;
		rpt = '0;
		if (!item.chunk_end)
			return;

		// good only when exactly 37 bytes, header in range and checksum matches
		ok = (pos == usp_pkg::POS_SUM) && (cap_hdr >= usp_pkg::HDR_MIN) &&
			(cap_hdr <= usp_pkg::HDR_MAX) && (cap_sum == rcv_sum);
		if (ok) begin
			sfail = cap_f3[1];
			inv = cap_f1[2];
			ovc = cap_f3[0];
			if (!model_seen) begin
				model_held = cap_hdr[1:0];
				model_seen = 1'b1;
			end
			// limit follows the header of this packet, not the latched model
			limit = (cap_hdr == usp_pkg::HDR_6KVA) ? lim_6kva : lim_other;
			if (cap_vbat < limit)
				crit_seen = 1'b1;

			// line flags stay up until the line state repeats
			if (sfail && line_good)
				fail_pend = 1'b1;
			if (!sfail && !line_good)
				return_pend = 1'b1;
			if (!sfail == line_good) begin
				fail_pend = 1'b0;
				return_pend = 1'b0;
			end
			line_good = !sfail;
			line_ev = usp_pkg::LINE_NONE;
			if (fail_pend)
				line_ev = usp_pkg::LINE_FAIL;
			if (return_pend)
				line_ev = usp_pkg::LINE_RETURN;

			// overcharge edges override inverter edges
			out_ev = usp_pkg::OUT_NONE;
			if (inv && !prev_inverter)
				out_ev = usp_pkg::OUT_INV_ON;
			if (prev_inverter && !inv)
				out_ev = usp_pkg::OUT_INV_OFF;
			prev_inverter = inv;
			if (ovc && !prev_ovc)
				out_ev = usp_pkg::OUT_OVC_START;
			if (prev_ovc && !ovc)
				out_ev = usp_pkg::OUT_OVC_END;
			prev_ovc = ovc;

			held_status.model_code = model_held;
			held_status.output_on = cap_f1[1];
			held_status.input_on = inv;
			held_status.bypass_on = cap_f1[3];
			held_status.low_battery = cap_f2[6];
			held_status.overcharge = ovc;
			held_status.source_fail = sfail;
			held_status.battery_critical = crit_seen;
			held_status.line_event = line_ev;
			held_status.output_event = out_ev;
			held_status.output_voltage_half = cap_f1[3] ?
				({1'b0, cap_vin} + usp_pkg::BYPASS_OFFSET) : {cap_vout, 1'b0};
		end
		rpt.packet_ok = ok;
		rpt.st = held_status;
		rcv_count = '0;
		rcv_sum = '0;
	endtask

	// one byte transaction on the rx channel, returns at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned      gap;
		logic             has_rpt;
		usp_pkg::report_t rpt;
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_data <= '{rx_byte: b, chunk_end: last};
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		predict_report('{rx_byte: b, chunk_end: last}, has_rpt, rpt);
		bytes_sent++;
		if (has_rpt)
			pending_reports.push_back(rpt);
	endtask

	task automatic send_chunk();
		foreach (chunk_buf[i])
			send_byte(chunk_buf[i], i == chunk_buf.size() - 1);
	endtask

	// 37-byte packet with random filler; bad_sum spoils the checksum
	task automatic build_packet(input logic [7:0] hdr, input logic [7:0] vin,
			input logic [7:0] vout, input logic [7:0] vbat, input logic [7:0] f1,
			input logic [7:0] f2, input logic [7:0] f3, input logic bad_sum);
		logic [7:0] sum;
		chunk_buf.delete();
		sum = '0;
		for (int i = 0; i < PKT_BYTES - 1; i++) begin
			case (6'(i))
				usp_pkg::POS_HDR:   chunk_buf.push_back(hdr);
				usp_pkg::POS_VIN:   chunk_buf.push_back(vin);
				usp_pkg::POS_VOUT:  chunk_buf.push_back(vout);
				usp_pkg::POS_VBAT:  chunk_buf.push_back(vbat);
				usp_pkg::POS_FLAG1: chunk_buf.push_back(f1);
				usp_pkg::POS_FLAG2: chunk_buf.push_back(f2);
				usp_pkg::POS_FLAG3: chunk_buf.push_back(f3);
				default:            chunk_buf.push_back(8'($urandom_range(0, 255)));
			endcase
			sum = sum + chunk_buf[i];
		end
		if (bad_sum)
			sum = sum + 8'($urandom_range(1, 255));
		chunk_buf.push_back(sum);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] vin,
			input logic [7:0] vout, input logic [7:0] vbat, input logic [7:0] f1,
			input logic [7:0] f2, input logic [7:0] f3, input logic bad_sum);
		build_packet(hdr, vin, vout, vbat, f1, f2, f3, bad_sum);
		send_chunk();
	endtask

	// stop offering bytes, let every report come out, then let the pipe settle
	task automatic drain();
		rx_valid <= 1'b0;
		while (pending_reports.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready, then back to idle
	task automatic write_limit(input logic idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == usp_pkg::REG_LIMIT_6KVA)
			lim_6kva = val;
		else
			lim_other = val;
		@(posedge clk);
	endtask

	// report checker: every accepted report transaction against the oldest expectation
	always @(posedge clk) begin
		usp_pkg::report_t want;
		if (arst_n && rpt_valid && !rpt_stall) begin
			if (pending_reports.size() == 0) begin
				if (field_errors < 10)
					$display("unexpected report transaction: %h", rpt_data);
				field_errors++;
			end else begin
				want = pending_reports.pop_front();
				if (want !== rpt_data) begin
					if (field_errors < 10)
						$display("report transaction: expected %h, got %h", want, rpt_data);
					field_errors++;
				end
			end
		end
	end

	// report-side stall: random stalls, plus the long hold-off when a test asks
	initial begin
		int unsigned n;
		rpt_stall = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_len > 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				rpt_stall <= 1'b1;
				// count the hold-off cycle by cycle
				while (n > 0) begin
					@(posedge clk);
					n--;
				end
			end else if (gaps_on && $urandom_range(0, 99) < 25) begin
				rpt_stall <= 1'b1;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3);
				repeat (n) @(posedge clk);
			end else begin
				rpt_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// bad chunks before any good packet all report zero status
	task automatic test_before_first_packet();
		send_packet(usp_pkg::HDR_MIN, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// single-byte chunk
		chunk_buf = '{8'hFF};
		send_chunk();
		// headers just outside the accepted range, checksum correct
		send_packet(8'hBF, 8'h10, 8'h20, 8'h30, 8'h0E, 8'h40, 8'h03, 1'b0);
		send_packet(8'hC4, 8'h10, 8'h20, 8'h30, 8'h0E, 8'h40, 8'h03, 1'b0);
		// one byte short
		build_packet(usp_pkg::HDR_MAX, 8'h01, 8'h02, 8'h03, 8'h0E, 8'h40, 8'h03, 1'b0);
		void'(chunk_buf.pop_back());
		send_chunk();
		// long chunk: a good packet followed by extra bytes
		build_packet(usp_pkg::HDR_6KVA, 8'h01, 8'h02, 8'h03, 8'h0E, 8'h40, 8'h03, 1'b0);
		repeat (3) chunk_buf.push_back(8'($urandom_range(0, 255)));
		send_chunk();
		drain();
	endtask

	// battery limit registers at their extremes; critical latches once and stays
	task automatic test_critical_limits();
		write_limit(usp_pkg::REG_LIMIT_6KVA, 8'd0);
		write_limit(usp_pkg::REG_LIMIT_OTHER, 8'd0);
		// first good packet latches model 3
		send_packet(usp_pkg::HDR_MAX, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(usp_pkg::HDR_6KVA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		drain();
		write_limit(usp_pkg::REG_LIMIT_6KVA, 8'd255);
		// other headers use the other limit, still zero
		send_packet(usp_pkg::HDR_MIN, 8'h00, 8'h00, 8'd254, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(usp_pkg::HDR_6KVA, 8'h00, 8'h00, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(usp_pkg::HDR_6KVA, 8'h00, 8'h00, 8'd254, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(8'hC1, 8'h00, 8'h00, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
		drain();
		write_limit(usp_pkg::REG_LIMIT_6KVA, usp_pkg::LIMIT_6KVA_RST);
		write_limit(usp_pkg::REG_LIMIT_OTHER, usp_pkg::LIMIT_OTHER_RST);
	endtask

	// line and output edge events, including return winning over a held failure
	task automatic test_status_events();
		// mains failure, inverter on, bypass with top input voltage
		send_packet(8'hC1, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h02, 1'b0);
		// mains return while the failure flag is still up
		send_packet(usp_pkg::HDR_MIN, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
		// line repeats so flags clear; overcharge starts
		send_packet(usp_pkg::HDR_MAX, 8'h00, 8'h80, 8'h80, 8'h02, 8'hBF, 8'h01, 1'b0);
		// overcharge ends in the same packet as inverter on
		send_packet(usp_pkg::HDR_6KVA, 8'h00, 8'h7F, 8'hB0, 8'h04, 8'h40, 8'hFC, 1'b0);
		send_packet(usp_pkg::HDR_MIN, 8'h00, 8'h01, 8'hB0, 8'h04, 8'h40, 8'h02, 1'b0);
		send_packet(usp_pkg::HDR_MIN, 8'h00, 8'h01, 8'hB0, 8'h04, 8'h40, 8'h02, 1'b0);
		// bad checksum repeats the held status
		send_packet(usp_pkg::HDR_MIN, 8'h55, 8'hAA, 8'h00, 8'hF7, 8'hFF, 8'hFD, 1'b1);
		drain();
	endtask

	// mostly well-formed packets with random content, plus broken chunks
	task automatic test_random_stream();
		int unsigned r, n, next_cfg;
		logic [7:0]  hdr;
		next_cfg = bytes_sent + 300;
		while (bytes_sent < 1100) begin
			if (bytes_sent >= next_cfg) begin
				drain();
				r = $urandom_range(0, 3);
				write_limit(usp_pkg::REG_LIMIT_6KVA, (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
					8'($urandom_range(0, 255)));
				write_limit(usp_pkg::REG_LIMIT_OTHER, 8'($urandom_range(0, 255)));
				next_cfg = bytes_sent + 300;
			end
			// now and then a back-to-back stretch
			gaps_on = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 99);
			hdr = usp_pkg::HDR_MIN + 8'($urandom_range(0, 3));
			if (r < 70) begin
				send_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 78) begin
				send_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
			end else if (r < 84) begin
				// any header, checksum right
				send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 93) begin
				// short chunk, half the time starting with a valid header
				n = $urandom_range(1, PKT_BYTES - 1);
				chunk_buf.delete();
				chunk_buf.push_back(($urandom_range(0, 1) == 0) ? hdr :
					8'($urandom_range(0, 255)));
				repeat (n - 1) chunk_buf.push_back(8'($urandom_range(0, 255)));
				send_chunk();
			end else begin
				// good packet run long
				build_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
				repeat ($urandom_range(1, 8)) chunk_buf.push_back(8'($urandom_range(0, 255)));
				send_chunk();
			end
		end
		gaps_on = 1'b1;
		drain();
	endtask

	// the report side holds reports off long enough that chunk ends back up the input
	task automatic test_report_backpressure();
		gaps_on = 1'b0;
		hold_off_len = 150;
		repeat (6) begin
			chunk_buf.delete();
			repeat ($urandom_range(2, 4)) chunk_buf.push_back(8'($urandom_range(0, 255)));
			send_chunk();
		end
		repeat (3)
			send_packet(usp_pkg::HDR_MIN + 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'b0);
		drain();
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_valid = 1'b0;
		rx_data = '0;
		field_errors = 0;
		bytes_sent = 0;
		gaps_on = 1'b1;
		hold_off_len = 0;

		// expected state after reset
		rcv_count = '0;
		rcv_sum = '0;
		{cap_hdr, cap_vin, cap_vout, cap_vbat} = '0;
		{cap_f1, cap_f2, cap_f3, cap_sum} = '0;
		model_seen = 1'b0;
		model_held = '0;
		line_good = 1'b0;
		fail_pend = 1'b0;
		return_pend = 1'b0;
		prev_inverter = 1'b0;
		prev_ovc = 1'b0;
		crit_seen = 1'b0;
		held_status = '0;
		lim_6kva = usp_pkg::LIMIT_6KVA_RST;
		lim_other = usp_pkg::LIMIT_OTHER_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_first_packet();
		test_critical_limits();
		test_status_events();
		test_random_stream();
		test_report_backpressure();

		if (field_errors == 0 && pending_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/usp_pkg.sv
hdl/ups_status_packet_receiver.sv
tb/testbench.sv
